// ----- hdl/png_pkg.sv -----
// Shared types, constants and the step program of the pink noise generator.
// Used by the controller, the datapath and the shared multiplier.
package png_pkg;

  localparam int STATE_W    = 48;
  localparam int HALF_W     = STATE_W / 2;
  localparam int COEF_W     = 21;
  localparam int A_W        = 32;
  localparam int SEED_W     = 20;
  localparam int SIG_FRAC   = 30;
  localparam int COEF_FRAC  = COEF_W - 3;
  localparam int Q_W        = 32;
  localparam int DIV_STEPS  = 2;
  localparam int PROD_W     = A_W + STATE_W;
  localparam int MAG_W      = PROD_W - COEF_FRAC;
  localparam int SAMPLE_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3 * COEF_W;
  localparam int NUM_UOPS   = 35;
  localparam int PC_W       = 6;
  localparam int CNT_W      = 6;

  localparam logic [SEED_W:0]   LCG_MUL = 21'd1664525;
  localparam logic [SEED_W-1:0] LCG_INC = 20'd52737;

  localparam logic signed [STATE_W-1:0] CLIP_LEVEL = 48'sd359666402;
  localparam logic signed [A_W-1:0]     FULL_SCALE = 32'sd2147483647;
  localparam logic signed [A_W-1:0]     DIRECT_K   = 32'sd36794537;
  localparam logic signed [A_W-1:0]     DELAYED_K  = 32'sd9531189;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HP1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HP2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LP1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LP2  = 3'd5;

  // Step program addresses.
  localparam logic [PC_W-1:0] UP_B5_SUM  = 6'd10;
  localparam logic [PC_W-1:0] UP_DIRECT  = 6'd11;
  localparam logic [PC_W-1:0] UP_DELAYED = 6'd12;
  localparam logic [PC_W-1:0] UP_BIQUAD  = 6'd13;
  localparam logic [PC_W-1:0] UP_CLIP    = 6'd33;

  // Slots inside one biquad section.
  localparam logic [2:0] BQ_FB1   = 3'd0;
  localparam logic [2:0] BQ_FB2   = 3'd1;
  localparam logic [2:0] BQ_TWICE = 3'd2;
  localparam logic [2:0] BQ_SHIFT = 3'd3;

  typedef enum logic [2:0] {
    A_GAIN, A_POLE, A_DIRECT, A_DELAYED, A_A1, A_A2, A_B0, A_FULL
  } asel_e;

  typedef enum logic [2:0] {
    B_WHITE, B_BRANCH, B_W1, B_W2, B_TMP, B_ACC
  } bsel_e;

  typedef enum logic [3:0] {
    WB_TMP, WB_BRANCH_ACC, WB_ACC_B5, WB_ACC_ADD, WB_B5, WB_ACC_SUB,
    WB_TWICE, WB_SHIFT, WB_ACC, WB_CLIP, WB_SCALE
  } wb_e;

  typedef struct packed {
    logic       is_mul;
    asel_e      asel;
    bsel_e      bsel;
    wb_e        wb;
    logic [2:0] idx;
  } uop_t;

  typedef struct packed {
    logic lcg;
    logic div_step;
    logic mul_start;
    logic wb_en;
    logic out_load;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic out_free;
  } status_t;

  function automatic logic signed [A_W-1:0] pole_k(input logic [2:0] i);
    logic signed [A_W-1:0] k;
    case (i)
      3'd0:    k = 32'sd1073156742;
      3'd1:    k = 32'sd1070505459;
      3'd2:    k = 32'sd1057041917;
      3'd3:    k = 32'sd983736167;
      3'd4:    k = 32'sd704739601;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic signed [A_W-1:0] gain_k(input logic [2:0] i);
    logic signed [A_W-1:0] k;
    case (i)
      3'd0:    k = 32'sd2127799;
      3'd1:    k = 32'sd2831482;
      3'd2:    k = 32'sd6906455;
      3'd3:    k = 32'sd15450635;
      3'd4:    k = 32'sd28973941;
      default: k = '0;
    endcase
    return k;
  endfunction

  // One step of the per-sample program: branch network, four biquads,
  // clipping and output scaling.
  function automatic uop_t uprog(input logic [PC_W-1:0] pc);
    uop_t            u;
    logic [PC_W-1:0] rel;
    logic [1:0]      n;
    logic [2:0]      sub;
    u.is_mul = 1'b0;
    u.asel   = A_FULL;
    u.bsel   = B_ACC;
    u.wb     = WB_ACC;
    u.idx    = '0;
    rel      = pc - UP_BIQUAD;
    if (rel >= 6'd15) begin
      n = 2'd3;  sub = 3'(rel - 6'd15);
    end else if (rel >= 6'd10) begin
      n = 2'd2;  sub = 3'(rel - 6'd10);
    end else if (rel >= 6'd5) begin
      n = 2'd1;  sub = 3'(rel - 6'd5);
    end else begin
      n = 2'd0;  sub = rel[2:0];
    end
    if (pc < UP_B5_SUM) begin
      u.is_mul = 1'b1;
      u.idx    = pc[3:1];
      if (!pc[0]) begin
        u.asel = A_GAIN;  u.bsel = B_WHITE;  u.wb = WB_TMP;
      end else begin
        u.asel = A_POLE;  u.bsel = B_BRANCH; u.wb = WB_BRANCH_ACC;
      end
    end else if (pc == UP_B5_SUM) begin
      u.wb = WB_ACC_B5;
    end else if (pc == UP_DIRECT) begin
      u.is_mul = 1'b1;  u.asel = A_DIRECT;  u.bsel = B_WHITE;  u.wb = WB_ACC_ADD;
    end else if (pc == UP_DELAYED) begin
      u.is_mul = 1'b1;  u.asel = A_DELAYED; u.bsel = B_WHITE;  u.wb = WB_B5;
    end else if (pc < UP_CLIP) begin
      u.idx = {1'b0, n};
      case (sub)
        BQ_FB1: begin
          u.is_mul = 1'b1;  u.asel = A_A1;  u.bsel = B_W1;  u.wb = WB_ACC_SUB;
        end
        BQ_FB2: begin
          u.is_mul = 1'b1;  u.asel = A_A2;  u.bsel = B_W2;  u.wb = WB_ACC_SUB;
        end
        BQ_TWICE: u.wb = WB_TWICE;
        BQ_SHIFT: u.wb = WB_SHIFT;
        default: begin
          u.is_mul = 1'b1;  u.asel = A_B0;  u.bsel = B_TMP;  u.wb = WB_ACC;
        end
      endcase
    end else if (pc == UP_CLIP) begin
      u.wb = WB_CLIP;
    end else begin
      u.is_mul = 1'b1;  u.asel = A_FULL;  u.bsel = B_ACC;  u.wb = WB_SCALE;
    end
    return u;
  endfunction

endpackage

// ----- hdl/png_mul.sv -----
// Shared multiply unit: signed 32 x 48 product in two 32 x 24 halves,
// rounded to nearest, shifted by 30 or 18 and saturated. Uses png_pkg.
module png_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [png_pkg::A_W-1:0]      a_i,
  input  logic signed [png_pkg::STATE_W-1:0]  b_i,
  input  logic                                sh30_i,
  output logic signed [png_pkg::STATE_W-1:0]  res_o,
  output logic                                done_o
);
  import png_pkg::*;

  typedef enum logic [2:0] {M_IDLE, M_LO, M_HI, M_SUM, M_SAT} mstate_e;

  mstate_e                 state_q;
  logic                    done_q;
  logic [A_W-1:0]          ua_q;
  logic [STATE_W-1:0]      ub_q;
  logic                    neg_q;
  logic                    sh30_q;
  logic [A_W+HALF_W-1:0]   lo_q, hi_q;
  logic [MAG_W-1:0]        mag_q;
  logic [STATE_W-1:0]      res_q;

  logic [HALF_W-1:0]       part_w;
  logic [A_W+HALF_W-1:0]   prod_w;
  logic [PROD_W-1:0]       full_w;
  logic [MAG_W-1:0]        mag_w;
  logic [STATE_W-1:0]      lim_w, satm_w;

  always_comb begin
    part_w = (state_q == M_HI) ? ub_q[STATE_W-1:HALF_W] : ub_q[HALF_W-1:0];
    prod_w = ua_q * part_w;
    full_w = {hi_q, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, lo_q}
           + (sh30_q ? (PROD_W'(1) << (SIG_FRAC - 1)) : (PROD_W'(1) << (COEF_FRAC - 1)));
    mag_w  = sh30_q ? {{(SIG_FRAC-COEF_FRAC){1'b0}}, full_w[PROD_W-1:SIG_FRAC]}
                    : full_w[PROD_W-1:COEF_FRAC];
    // The negative limit is one larger in magnitude than the positive one.
    lim_w  = neg_q ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
    satm_w = (mag_q > {{(MAG_W-STATE_W){1'b0}}, lim_w}) ? lim_w : mag_q[STATE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == M_SAT);
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            ua_q    <= a_i[A_W-1] ? A_W'(-a_i) : A_W'(a_i);
            ub_q    <= b_i[STATE_W-1] ? STATE_W'(-b_i) : STATE_W'(b_i);
            neg_q   <= a_i[A_W-1] ^ b_i[STATE_W-1];
            sh30_q  <= sh30_i;
            state_q <= M_LO;
          end
        end
        M_LO: begin
          lo_q    <= prod_w;
          state_q <= M_HI;
        end
        M_HI: begin
          hi_q    <= prod_w;
          state_q <= M_SUM;
        end
        M_SUM: begin
          mag_q   <= mag_w;
          state_q <= M_SAT;
        end
        M_SAT: begin
          res_q   <= neg_q ? (~satm_w + 1'b1) : satm_w;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign res_o  = $signed(res_q);
  assign done_o = done_q;

endmodule

// ----- hdl/png_datapath.sv -----
// Datapath: configuration registers, LCG, reduction that maps the LCG value
// to white noise, filter state, saturating adders and output register.
// Uses png_pkg and png_mul.
module png_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [png_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [png_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  png_pkg::cmd_t                        cmd_i,
  output png_pkg::status_t                     status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [png_pkg::SAMPLE_W-1:0]  pink_sample_o,
  output logic                                 clipped_o
);
  import png_pkg::*;

  logic                        mode_q;
  logic [2:0]                  word_size_q;
  logic [CFG_DATA_W-1:0]       coef_q [4];
  logic [SEED_W-1:0]           seed_q;
  logic [Q_W-1:0]              quo_q;
  logic [Q_W-1:0]              red_q;
  logic signed [STATE_W-1:0]   br_q [5];
  logic signed [STATE_W-1:0]   br5_q;
  logic signed [STATE_W-1:0]   w1_q [4];
  logic signed [STATE_W-1:0]   w2_q [4];
  logic signed [STATE_W-1:0]   acc_q, tmp_q;
  logic                        clip_q;
  logic [SAMPLE_W-1:0]         sample_q;
  logic                        out_valid_q;
  logic [SAMPLE_W-1:0]         out_sample_q;
  logic                        out_clip_q;

  logic [SEED_W-1:0]           randmax_w, seed_next_w;
  logic [2*SEED_W-1:0]         lcg_prod_w;
  logic [Q_W-1:0]              seed_sh_w, red_hi_w, red_lo_w, quo_w;
  logic signed [STATE_W-1:0]   white_w, brsel_w, w1_w, w2_w;
  logic [CFG_DATA_W-1:0]       coef_w;
  logic signed [A_W-1:0]       a_w;
  logic signed [STATE_W-1:0]   b_w, p_w;
  logic                        sh30_w, mul_done_w;
  logic signed [STATE_W-1:0]   nb_w, acc_br_w, acc_b5_w, acc_add_w, acc_sub_w;
  logic signed [STATE_W-1:0]   twice_w, tmp_twice_w, tmp_w2_w, kept_w;
  logic [2:0]                  ws_w;
  uop_t                        u;

  function automatic logic signed [STATE_W-1:0] sat(input logic signed [STATE_W+1:0] v);
    logic signed [STATE_W+1:0] hi, lo;
    hi = {3'b000, {(STATE_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[STATE_W-1:0];
    if (v < lo) return lo[STATE_W-1:0];
    return v[STATE_W-1:0];
  endfunction

  function automatic logic signed [STATE_W+1:0] ext(input logic signed [STATE_W-1:0] v);
    return {{2{v[STATE_W-1]}}, v};
  endfunction

  function automatic logic signed [A_W-1:0] cfield(input logic [COEF_W-1:0] f);
    return {{(A_W-COEF_W){f[COEF_W-1]}}, f};
  endfunction

  assign u = cmd_i.uop;

  always_comb begin
    randmax_w   = mode_q ? {SEED_W{1'b1}} : {1'b0, {(SEED_W-1){1'b1}}};
    lcg_prod_w  = seed_q * LCG_MUL[SEED_W-1:0];
    seed_next_w = (lcg_prod_w[SEED_W-1:0] + LCG_INC) & randmax_w;
    // The divisor is 2^k - 1, so seed * 2^31 / divisor is seed * 2^(31-k) plus
    // the quotient of a small remainder, found by folding the high part of the
    // remainder onto its low part: 2^k is one modulo the divisor.
    seed_sh_w   = mode_q ? {1'b0, seed_next_w, {(Q_W-SEED_W-1){1'b0}}}
                         : {seed_next_w, {(Q_W-SEED_W){1'b0}}};
    red_hi_w    = mode_q ? (red_q >> SEED_W) : (red_q >> (SEED_W - 1));
    red_lo_w    = red_q & {{(Q_W-SEED_W){1'b0}}, randmax_w};
    quo_w       = quo_q + {{(Q_W-1){1'b0}},
                           (red_q >= {{(Q_W-SEED_W){1'b0}}, randmax_w})};
    white_w     = $signed({{(STATE_W-Q_W){1'b0}}, quo_w})
                - $signed(STATE_W'(1) << SIG_FRAC);

    brsel_w = br_q[u.idx];
    w1_w    = w1_q[u.idx[1:0]];
    w2_w    = w2_q[u.idx[1:0]];
    coef_w  = coef_q[u.idx[1:0]];

    case (u.asel)
      A_GAIN:    a_w = gain_k(u.idx);
      A_POLE:    a_w = pole_k(u.idx);
      A_DIRECT:  a_w = DIRECT_K;
      A_DELAYED: a_w = DELAYED_K;
      A_A1:      a_w = cfield(coef_w[COEF_W-1:0]);
      A_A2:      a_w = cfield(coef_w[2*COEF_W-1:COEF_W]);
      A_B0:      a_w = cfield(coef_w[3*COEF_W-1:2*COEF_W]);
      default:   a_w = FULL_SCALE;
    endcase
    sh30_w = !(u.asel == A_A1 || u.asel == A_A2 || u.asel == A_B0);

    case (u.bsel)
      B_WHITE:  b_w = white_w;
      B_BRANCH: b_w = brsel_w;
      B_W1:     b_w = w1_w;
      B_W2:     b_w = w2_w;
      B_TMP:    b_w = tmp_q;
      default:  b_w = acc_q;
    endcase

    nb_w        = sat(ext(p_w) + ext(tmp_q));
    acc_br_w    = sat(ext(acc_q) + ext(nb_w));
    acc_b5_w    = sat(ext(acc_q) + ext(br5_q));
    acc_add_w   = sat(ext(acc_q) + ext(p_w));
    acc_sub_w   = sat(ext(acc_q) - ext(p_w));
    twice_w     = sat(ext(w1_w) + ext(w1_w));
    // Sections two and three are the lowpass pair.
    tmp_twice_w = u.idx[1] ? sat(ext(acc_q) + ext(twice_w))
                           : sat(ext(acc_q) - ext(twice_w));
    tmp_w2_w    = sat(ext(tmp_q) + ext(w2_w));

    ws_w = (word_size_q > 3'd4) ? 3'd4 : word_size_q;
    case (ws_w)
      3'd1:    kept_w = p_w >>> 24;
      3'd2:    kept_w = p_w >>> 16;
      3'd3:    kept_w = p_w >>> 8;
      3'd4:    kept_w = p_w;
      default: kept_w = '0;
    endcase
  end

  png_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (a_w),
    .b_i     (b_w),
    .sh30_i  (sh30_w),
    .res_o   (p_w),
    .done_o  (mul_done_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      word_size_q <= 3'd3;
      for (int i = 0; i < 4; i++) coef_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE: mode_q      <= cfg_data_i[0];
        CFG_WORD: word_size_q <= cfg_data_i[2:0];
        CFG_HP1:  coef_q[0]   <= cfg_data_i;
        CFG_HP2:  coef_q[1]   <= cfg_data_i;
        CFG_LP1:  coef_q[2]   <= cfg_data_i;
        CFG_LP2:  coef_q[3]   <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Reduction registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.lcg) begin
      quo_q <= seed_sh_w;
      red_q <= seed_sh_w + {{(Q_W-SEED_W+1){1'b0}}, randmax_w[SEED_W-1:1]};
    end else if (cmd_i.div_step) begin
      quo_q <= quo_q + red_hi_w;
      red_q <= red_hi_w + red_lo_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      br5_q  <= '0;
      for (int i = 0; i < 5; i++) br_q[i] <= '0;
      for (int i = 0; i < 4; i++) begin
        w1_q[i] <= '0;
        w2_q[i] <= '0;
      end
      clip_q   <= 1'b0;
      sample_q <= '0;
    end else begin
      if (cmd_i.lcg) seed_q <= seed_next_w;
      if (cmd_i.wb_en) begin
        case (u.wb)
          WB_BRANCH_ACC: br_q[u.idx] <= nb_w;
          WB_B5:         br5_q <= p_w;
          WB_SHIFT: begin
            w2_q[u.idx[1:0]] <= w1_w;
            w1_q[u.idx[1:0]] <= acc_q;
          end
          WB_CLIP:  clip_q   <= (acc_q > CLIP_LEVEL) || (acc_q < -CLIP_LEVEL);
          WB_SCALE: sample_q <= kept_w[SAMPLE_W-1:0];
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lcg) begin
      acc_q <= '0;
    end else if (cmd_i.wb_en) begin
      case (u.wb)
        WB_TMP:        tmp_q <= p_w;
        WB_BRANCH_ACC: acc_q <= acc_br_w;
        WB_ACC_B5:     acc_q <= acc_b5_w;
        WB_ACC_ADD:    acc_q <= acc_add_w;
        WB_ACC_SUB:    acc_q <= acc_sub_w;
        WB_TWICE:      tmp_q <= tmp_twice_w;
        WB_SHIFT:      tmp_q <= tmp_w2_w;
        WB_ACC:        acc_q <= p_w;
        WB_CLIP: begin
          if (acc_q > CLIP_LEVEL)       acc_q <= CLIP_LEVEL;
          else if (acc_q < -CLIP_LEVEL) acc_q <= -CLIP_LEVEL;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_sample_q <= sample_q;
      out_clip_q   <= clip_q;
    end
  end

  assign status_o.mul_done = mul_done_w;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign pink_sample_o = $signed(out_sample_q);
  assign clipped_o     = out_clip_q;

endmodule

// ----- hdl/png_ctrl.sv -----
// Controller: accepts ticks and walks the per-sample step program,
// issuing commands to the datapath. Uses png_pkg.
module png_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              tick_i,
  output logic              in_stall_o,
  input  png_pkg::status_t  status_i,
  output png_pkg::cmd_t     cmd_o
);
  import png_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_ISSUE, S_MWAIT, S_FINISH} state_e;

  state_e           state_q;
  logic [PC_W-1:0]  pc_q;
  logic [CNT_W-1:0] cnt_q;
  cmd_t             cmd_q;
  cmd_t             cmd_d;
  uop_t             u_w;
  logic             last_w;

  assign u_w    = uprog(pc_q);
  assign last_w = (pc_q == PC_W'(NUM_UOPS - 1));

  always_comb begin
    cmd_d     = '0;
    cmd_d.uop = u_w;
    case (state_q)
      S_IDLE:   cmd_d.lcg      = in_valid_i && tick_i;
      S_DIV:    cmd_d.div_step = 1'b1;
      S_ISSUE: begin
        cmd_d.mul_start = u_w.is_mul;
        cmd_d.wb_en     = !u_w.is_mul;
      end
      S_MWAIT:  cmd_d.wb_en    = status_i.mul_done;
      S_FINISH: cmd_d.out_load = status_i.out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      cnt_q   <= '0;
      cmd_q   <= '0;
    end else begin
      cmd_q <= cmd_d;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && tick_i) begin
            pc_q    <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= S_ISSUE;
        end
        S_ISSUE: begin
          if (u_w.is_mul) begin
            state_q <= S_MWAIT;
          end else begin
            pc_q    <= pc_q + 1'b1;
            state_q <= last_w ? S_FINISH : S_ISSUE;
          end
        end
        S_MWAIT: begin
          if (status_i.mul_done) begin
            pc_q    <= pc_q + 1'b1;
            state_q <= last_w ? S_FINISH : S_ISSUE;
          end
        end
        S_FINISH: begin
          if (status_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_o      = cmd_q;

endmodule

// ----- hdl/pink_noise_generator_unit.sv -----
// Top level of the pink noise generator: controller plus datapath.
// Uses png_pkg, png_ctrl and png_datapath.
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------
//   input   | in_valid_i / in_stall_o | tick_i
//   output  | out_valid_o/out_stall_i | pink_sample_o, clipped_o
//   config  | cfg_we_i                | cfg_index_i, cfg_data_i
//
// A tick of one runs the LCG step, two folding steps that map the LCG value
// to white noise, 25 multiplies on the one shared 32 x 24 multiplier, ten
// add steps and the load of the output register before the next tick can
// be taken.
// A tick of zero is taken while idle and gives no item.
// Reset clears the LCG seed and all filter state; word size resets to three.
// A finished item waits in the output register while the next tick is taken;
// the load of the next item waits for as long as that one stays stalled.
module pink_noise_generator_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 tick_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [png_pkg::SAMPLE_W-1:0]  pink_sample_o,
  output logic                                 clipped_o,
  input  logic                                 cfg_we_i,
  input  logic [png_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [png_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import png_pkg::*;

  cmd_t    cmd;
  status_t status;

  png_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .tick_i     (tick_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  png_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pink_sample_o (pink_sample_o),
    .clipped_o     (clipped_o)
  );

`ifndef SYNTHESIS
  // A tick that is taken must block the input until its item is done.
  a_tick_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && tick_i) |=> in_stall_o)
    else $error("input not blocked after tick");

  // The controller issues at most one datapath action per cycle.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.lcg, cmd.div_step, cmd.mul_start, cmd.wb_en, cmd.out_load}))
    else $error("more than one datapath command");

  // A new item never overwrites one that is still waiting at the output.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten");
`endif

endmodule
